[sv/atcr_pkg.sv]
// types, character codes and constants shared by the console renderer
package atcr_pkg;

    typedef enum logic [1:0] {
        OP_DRAW    = 2'd0,
        OP_CLEAR   = 2'd1,
        OP_SCROLL  = 2'd2,
        OP_PRESENT = 2'd3
    } t_op;

    typedef enum logic [3:0] {
        B_IDLE,
        B_WRAP,
        B_SCROLL,
        B_BODY,
        B_LF_SCROLL,
        B_TDRAW,
        B_TUNDER,
        B_UNDER,
        B_EOB
    } t_bstate;

    // register indexes on the configuration port
    localparam logic REG_TEXT_COLUMNS = 1'b0;
    localparam logic REG_TEXT_ROWS    = 1'b1;

    localparam logic [8:0] RESET_COLUMNS = 9'd80;
    localparam logic [8:0] RESET_ROWS    = 9'd25;
    localparam logic [8:0] MIN_COLUMNS   = 9'd2;
    localparam logic [8:0] MIN_ROWS      = 9'd1;

    localparam logic [7:0] CH_BS         = 8'd8;
    localparam logic [7:0] CH_TAB        = 8'd9;
    localparam logic [7:0] CH_LF         = 8'd10;
    localparam logic [7:0] CH_CR         = 8'd13;
    localparam logic [7:0] CH_ESC        = 8'd27;
    localparam logic [7:0] CH_SPACE      = 8'd32;
    localparam logic [7:0] CH_ZERO       = 8'd48;
    localparam logic [7:0] CH_NINE       = 8'd57;
    localparam logic [7:0] CH_SEMI       = 8'd59;
    localparam logic [7:0] CH_LBRACKET   = 8'd91;
    localparam logic [7:0] CH_UNDERSCORE = 8'd95;
    localparam logic [7:0] CH_M          = 8'd109;

    localparam logic [4:0] COLOR_WHITE = 5'd16;

    localparam logic [9:0] SGR_FG_LO     = 10'd30;
    localparam logic [9:0] SGR_FG_HI     = 10'd37;
    localparam logic [9:0] SGR_BG_LO     = 10'd40;
    localparam logic [9:0] SGR_BG_HI     = 10'd47;
    localparam logic [9:0] SGR_FG_BR_LO  = 10'd90;
    localparam logic [9:0] SGR_FG_BR_HI  = 10'd97;
    localparam logic [9:0] SGR_BG_BR_LO  = 10'd100;
    localparam logic [9:0] SGR_BG_BR_HI  = 10'd107;
    localparam logic [4:0] BRIGHT_OFFSET = 5'd8;
    localparam logic [1:0] MAX_DIGITS    = 2'd3;

    localparam logic [1:0] TAB_LAST = 2'd3;   // four spaces per tab

    localparam int Q_DEPTH = 4;
    localparam int Q_AW    = 2;

    // one classified command from front to back
    typedef struct packed {
        logic       is_char;
        logic [7:0] ch;
        logic [4:0] fg;
        logic       eob;
    } t_cmd;

    // effective screen geometry after clamping
    typedef struct packed {
        logic [8:0] cols;
        logic [8:0] rows;
    } t_geom;

endpackage

[sv/atcr_ifs.sv]
// stream and configuration channel interfaces of the console renderer
interface atcr_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] char_code;
    logic       end_of_buffer;
    modport source (output valid, output char_code, output end_of_buffer, input ready);
    modport sink (input valid, input char_code, input end_of_buffer, output ready);
endinterface

interface atcr_out_if;
    logic            valid;
    logic            ready;
    atcr_pkg::t_op   op;
    logic [7:0]      cell_col;
    logic [7:0]      cell_row;
    logic [7:0]      glyph;
    logic [4:0]      color_index;
    logic            last;
    modport source (output valid, output op, output cell_col, output cell_row,
                    output glyph, output color_index, output last, input ready);
    modport sink (input valid, input op, input cell_col, input cell_row,
                  input glyph, input color_index, input last, output ready);
endinterface

interface atcr_cfg_if;
    logic       valid;
    logic       ready;
    logic       index;
    logic [8:0] data;
    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

[sv/atcr_front.sv]
// front end: escape sequence parser and byte classifier
module atcr_front (
    input  logic            i_clk,
    input  logic            i_rst_n,
    atcr_in_if.sink         i_char,
    input  logic            i_q_full,
    output logic            o_push,
    output atcr_pkg::t_cmd  o_cmd
);

    logic       r_seen, n_seen;
    logic       r_inseq, n_inseq;
    logic [9:0] r_code, n_code;
    logic [1:0] r_dc, n_dc;
    logic [4:0] r_pending, n_pending;
    logic [4:0] r_fg, n_fg;
    logic       w_accept;
    logic       w_is_char;
    logic       w_digit;
    logic [7:0] w_ch;

    function automatic logic [4:0] apply_code(input logic [9:0] code, input logic [4:0] cur);
        logic [4:0] res;
        res = cur;
        if (code == 10'd0) begin
            res = atcr_pkg::COLOR_WHITE;
        end else if (code >= atcr_pkg::SGR_FG_LO && code <= atcr_pkg::SGR_FG_HI) begin
            res = 5'(code - atcr_pkg::SGR_FG_LO);
        end else if (code >= atcr_pkg::SGR_FG_BR_LO && code <= atcr_pkg::SGR_FG_BR_HI) begin
            res = 5'(code - atcr_pkg::SGR_FG_BR_LO) + atcr_pkg::BRIGHT_OFFSET;
        end else if (code >= atcr_pkg::SGR_BG_LO && code <= atcr_pkg::SGR_BG_HI) begin
            res = 5'(code - atcr_pkg::SGR_BG_LO);
        end else if (code >= atcr_pkg::SGR_BG_BR_LO && code <= atcr_pkg::SGR_BG_BR_HI) begin
            res = 5'(code - atcr_pkg::SGR_BG_BR_LO) + atcr_pkg::BRIGHT_OFFSET;
        end
        return res;
    endfunction

    assign i_char.ready = !i_q_full;
    assign w_accept     = i_char.valid && !i_q_full;
    assign w_ch         = i_char.char_code;
    assign w_digit      = (w_ch >= atcr_pkg::CH_ZERO) && (w_ch <= atcr_pkg::CH_NINE);

    always_comb begin
        n_seen    = r_seen;
        n_inseq   = r_inseq;
        n_code    = r_code;
        n_dc      = r_dc;
        n_pending = r_pending;
        n_fg      = r_fg;
        w_is_char = 1'b0;
        if (w_ch == atcr_pkg::CH_ESC) begin
            n_seen = 1'b1;
        end else if (w_ch == atcr_pkg::CH_LBRACKET && r_seen) begin
            n_inseq = 1'b1;
            n_dc    = 2'd0;
            n_code  = 10'd0;
        end else if (r_inseq && w_digit) begin
            if (r_dc < atcr_pkg::MAX_DIGITS) begin
                n_code = 10'(r_code * 10 + 10'(w_ch - atcr_pkg::CH_ZERO));
                n_dc   = r_dc + 2'd1;
            end
        end else if (r_inseq && (w_ch == atcr_pkg::CH_SEMI || w_ch == atcr_pkg::CH_M)) begin
            n_pending = apply_code(r_code, r_pending);
            n_code    = 10'd0;
            n_dc      = 2'd0;
            if (w_ch == atcr_pkg::CH_M) begin
                n_fg    = n_pending;
                n_seen  = 1'b0;
                n_inseq = 1'b0;
            end
        end else begin
            w_is_char = 1'b1;
        end
        // end of buffer drops any unfinished sequence
        if (i_char.end_of_buffer) begin
            n_seen    = 1'b0;
            n_inseq   = 1'b0;
            n_code    = 10'd0;
            n_dc      = 2'd0;
            n_pending = n_fg;
        end
    end

    assign o_push        = w_accept && (w_is_char || i_char.end_of_buffer);
    assign o_cmd.is_char = w_is_char;
    assign o_cmd.ch      = w_ch;
    assign o_cmd.fg      = r_fg;
    assign o_cmd.eob     = i_char.end_of_buffer;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seen    <= 1'b0;
            r_inseq   <= 1'b0;
            r_code    <= 10'd0;
            r_dc      <= 2'd0;
            r_pending <= atcr_pkg::COLOR_WHITE;
            r_fg      <= atcr_pkg::COLOR_WHITE;
        end else if (w_accept) begin
            r_seen    <= n_seen;
            r_inseq   <= n_inseq;
            r_code    <= n_code;
            r_dc      <= n_dc;
            r_pending <= n_pending;
            r_fg      <= n_fg;
        end
    end

endmodule

[sv/atcr_queue.sv]
// small command queue between front and back
module atcr_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  atcr_pkg::t_cmd  i_data,
    input  logic            i_pop,
    output logic            o_valid,
    output logic            o_full,
    output atcr_pkg::t_cmd  o_data
);

    atcr_pkg::t_cmd                r_mem [atcr_pkg::Q_DEPTH];
    logic [atcr_pkg::Q_AW-1:0]     r_wr, r_rd;
    logic [atcr_pkg::Q_AW:0]       r_cnt;

    assign o_valid = (r_cnt != '0);
    assign o_full  = (r_cnt == (atcr_pkg::Q_AW+1)'(atcr_pkg::Q_DEPTH));
    assign o_data  = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= r_rd + 1'b1;
            end
            case ({i_push, i_pop})
                2'b10:   r_cnt <= r_cnt + 1'b1;
                2'b01:   r_cnt <= r_cnt - 1'b1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule

[sv/atcr_back.sv]
// back end: cursor sequencer that issues cell commands through an output register
module atcr_back (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  atcr_pkg::t_geom i_geom,
    input  logic            i_q_valid,
    input  atcr_pkg::t_cmd  i_q_data,
    output logic            o_pop,
    atcr_out_if.source      o_cmd
);

    atcr_pkg::t_bstate r_state, n_state;
    atcr_pkg::t_cmd    r_cmd, n_cmd;
    logic [7:0]        r_col, n_col;
    logic [7:0]        r_row, n_row;
    logic              r_tab, n_tab;
    logic [1:0]        r_tcnt, n_tcnt;

    logic              r_ovalid;
    atcr_pkg::t_op     r_op;
    logic [7:0]        r_ocol, r_orow, r_glyph;
    logic [4:0]        r_color;
    logic              r_last;

    logic              w_free;
    logic              w_wrap;
    logic              w_row_adv;
    logic              e_valid;
    atcr_pkg::t_op     e_op;
    logic [7:0]        e_col, e_row, e_glyph;
    logic [4:0]        e_color;
    logic              e_last;

    assign w_free    = !r_ovalid || o_cmd.ready;
    assign w_wrap    = ({1'b0, r_col} + 9'd1) >= i_geom.cols;
    assign w_row_adv = ({1'b0, r_row} + 9'd1) < i_geom.rows;

    always_comb begin
        n_state = r_state;
        n_cmd   = r_cmd;
        n_col   = r_col;
        n_row   = r_row;
        n_tab   = r_tab;
        n_tcnt  = r_tcnt;
        o_pop   = 1'b0;
        e_valid = 1'b0;
        e_op    = atcr_pkg::OP_DRAW;
        e_col   = 8'd0;
        e_row   = 8'd0;
        e_glyph = 8'd0;
        e_color = 5'd0;
        e_last  = 1'b0;
        case (r_state)
            atcr_pkg::B_IDLE: begin
                if (i_q_valid) begin
                    o_pop   = 1'b1;
                    n_cmd   = i_q_data;
                    n_tab   = 1'b0;
                    n_state = i_q_data.is_char ? atcr_pkg::B_WRAP : atcr_pkg::B_EOB;
                end
            end
            atcr_pkg::B_WRAP: begin
                if (!w_wrap) begin
                    n_state = r_tab ? atcr_pkg::B_TDRAW : atcr_pkg::B_BODY;
                end else if (w_free) begin
                    e_valid = 1'b1;
                    e_op    = atcr_pkg::OP_CLEAR;
                    e_col   = r_col;
                    e_row   = r_row;
                    n_col   = 8'd0;
                    if (w_row_adv) begin
                        n_row   = r_row + 8'd1;
                        n_state = r_tab ? atcr_pkg::B_TDRAW : atcr_pkg::B_BODY;
                    end else begin
                        n_state = atcr_pkg::B_SCROLL;
                    end
                end
            end
            atcr_pkg::B_SCROLL: begin
                if (w_free) begin
                    e_valid = 1'b1;
                    e_op    = atcr_pkg::OP_SCROLL;
                    n_state = r_tab ? atcr_pkg::B_TDRAW : atcr_pkg::B_BODY;
                end
            end
            atcr_pkg::B_BODY: begin
                case (r_cmd.ch)
                    atcr_pkg::CH_LF: begin
                        if (w_free) begin
                            e_valid = 1'b1;
                            e_op    = atcr_pkg::OP_CLEAR;
                            e_col   = r_col;
                            e_row   = r_row;
                            n_col   = 8'd0;
                            if (w_row_adv) begin
                                n_row   = r_row + 8'd1;
                                n_state = atcr_pkg::B_UNDER;
                            end else begin
                                n_state = atcr_pkg::B_LF_SCROLL;
                            end
                        end
                    end
                    atcr_pkg::CH_CR: begin
                        n_col   = 8'd0;
                        n_state = atcr_pkg::B_UNDER;
                    end
                    atcr_pkg::CH_BS: begin
                        if (w_free) begin
                            e_valid = 1'b1;
                            e_col   = r_col;
                            e_row   = r_row;
                            e_glyph = atcr_pkg::CH_SPACE;
                            e_color = r_cmd.fg;
                            if (r_col != 8'd0) begin
                                n_col = r_col - 8'd1;
                            end
                            n_state = atcr_pkg::B_UNDER;
                        end
                    end
                    atcr_pkg::CH_TAB: begin
                        n_tab   = 1'b1;
                        n_tcnt  = 2'd0;
                        n_state = atcr_pkg::B_WRAP;
                    end
                    default: begin
                        if (w_free) begin
                            e_valid = 1'b1;
                            e_col   = r_col;
                            e_row   = r_row;
                            e_glyph = r_cmd.ch;
                            e_color = r_cmd.fg;
                            n_col   = r_col + 8'd1;
                            n_state = atcr_pkg::B_UNDER;
                        end
                    end
                endcase
            end
            atcr_pkg::B_LF_SCROLL: begin
                if (w_free) begin
                    e_valid = 1'b1;
                    e_op    = atcr_pkg::OP_SCROLL;
                    n_state = atcr_pkg::B_UNDER;
                end
            end
            atcr_pkg::B_TDRAW: begin
                if (w_free) begin
                    e_valid = 1'b1;
                    e_col   = r_col;
                    e_row   = r_row;
                    e_glyph = atcr_pkg::CH_SPACE;
                    e_color = r_cmd.fg;
                    n_col   = r_col + 8'd1;
                    n_state = atcr_pkg::B_TUNDER;
                end
            end
            atcr_pkg::B_TUNDER: begin
                if (w_free) begin
                    e_valid = 1'b1;
                    e_col   = r_col;
                    e_row   = r_row;
                    e_glyph = atcr_pkg::CH_UNDERSCORE;
                    e_color = r_cmd.fg;
                    if (r_tcnt == atcr_pkg::TAB_LAST) begin
                        n_tab   = 1'b0;
                        n_state = atcr_pkg::B_UNDER;
                    end else begin
                        n_tcnt  = r_tcnt + 2'd1;
                        n_state = atcr_pkg::B_WRAP;
                    end
                end
            end
            atcr_pkg::B_UNDER: begin
                if (w_free) begin
                    e_valid = 1'b1;
                    e_col   = r_col;
                    e_row   = r_row;
                    e_glyph = atcr_pkg::CH_UNDERSCORE;
                    e_color = r_cmd.fg;
                    e_last  = !r_cmd.eob;
                    n_state = r_cmd.eob ? atcr_pkg::B_EOB : atcr_pkg::B_IDLE;
                end
            end
            atcr_pkg::B_EOB: begin
                if (w_free) begin
                    e_valid = 1'b1;
                    e_op    = atcr_pkg::OP_PRESENT;
                    e_last  = 1'b1;
                    n_state = atcr_pkg::B_IDLE;
                end
            end
            default: begin
                n_state = atcr_pkg::B_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= atcr_pkg::B_IDLE;
            r_col   <= 8'd0;
            r_row   <= 8'd0;
            r_tab   <= 1'b0;
            r_tcnt  <= 2'd0;
        end else begin
            r_state <= n_state;
            r_col   <= n_col;
            r_row   <= n_row;
            r_tab   <= n_tab;
            r_tcnt  <= n_tcnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd <= n_cmd;
    end

    // output register, reloads on the same edge as a transfer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (e_valid) begin
            r_ovalid <= 1'b1;
        end else if (o_cmd.ready) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (e_valid) begin
            r_op    <= e_op;
            r_ocol  <= e_col;
            r_orow  <= e_row;
            r_glyph <= e_glyph;
            r_color <= e_color;
            r_last  <= e_last;
        end
    end

    assign o_cmd.valid       = r_ovalid;
    assign o_cmd.op          = r_op;
    assign o_cmd.cell_col    = r_ocol;
    assign o_cmd.cell_row    = r_orow;
    assign o_cmd.glyph       = r_glyph;
    assign o_cmd.color_index = r_color;
    assign o_cmd.last        = r_last;

endmodule

[sv/ansi_text_console_renderer.sv]
// top level of the ansi colour text console renderer
//
//  channel  dir  payload                                          transfer
//  i_char   in   char_code[7:0], end_of_buffer                    valid && ready
//  i_cfg    in   index (0 text_columns, 1 text_rows), data[8:0]   valid && ready
//  o_cmd    out  op, cell_col, cell_row, glyph, color_index, last valid && ready
//
//  a printable byte runs the back sequencer steps fetch, wrap check, glyph and underscore;
//  a wrap clears in the wrap check step and adds a scroll step only when it scrolls.
//  a tab repeats wrap check, space, underscore per space; end of buffer adds a present step.
//  parser-only bytes stay in the front and reach the back only when they end the buffer.
//  a 4-entry command queue lets the front keep accepting while the back works or stalls.
//  reset is synchronous: cursor, colours, parser and queue clear, geometry returns to 80x25.
//  o_cmd stalls hold the back at its output register; i_char stalls only on a full queue.
module ansi_text_console_renderer #(
    parameter int MAX_COLUMNS = 256,
    parameter int MAX_ROWS    = 256
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    atcr_in_if.sink     i_char,
    atcr_cfg_if.sink    i_cfg,
    atcr_out_if.source  o_cmd
);

    logic [8:0]        r_cols;
    logic [8:0]        r_rows;
    atcr_pkg::t_geom   w_geom;
    logic              w_push;
    logic              w_pop;
    logic              w_q_valid;
    logic              w_q_full;
    atcr_pkg::t_cmd    w_push_cmd;
    atcr_pkg::t_cmd    w_q_data;

    localparam logic [8:0] MaxCols = 9'(MAX_COLUMNS);
    localparam logic [8:0] MaxRows = 9'(MAX_ROWS);

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cols <= atcr_pkg::RESET_COLUMNS;
            r_rows <= atcr_pkg::RESET_ROWS;
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                atcr_pkg::REG_TEXT_COLUMNS: r_cols <= i_cfg.data;
                atcr_pkg::REG_TEXT_ROWS:    r_rows <= i_cfg.data;
                default: ;
            endcase
        end
    end

    // clamp geometry to the supported range
    always_comb begin
        if (r_cols < atcr_pkg::MIN_COLUMNS) begin
            w_geom.cols = atcr_pkg::MIN_COLUMNS;
        end else if (r_cols > MaxCols) begin
            w_geom.cols = MaxCols;
        end else begin
            w_geom.cols = r_cols;
        end
        if (r_rows < atcr_pkg::MIN_ROWS) begin
            w_geom.rows = atcr_pkg::MIN_ROWS;
        end else if (r_rows > MaxRows) begin
            w_geom.rows = MaxRows;
        end else begin
            w_geom.rows = r_rows;
        end
    end

    atcr_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_char   (i_char),
        .i_q_full (w_q_full),
        .o_push   (w_push),
        .o_cmd    (w_push_cmd)
    );

    atcr_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_data  (w_push_cmd),
        .i_pop   (w_pop),
        .o_valid (w_q_valid),
        .o_full  (w_q_full),
        .o_data  (w_q_data)
    );

    atcr_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_geom    (w_geom),
        .i_q_valid (w_q_valid),
        .i_q_data  (w_q_data),
        .o_pop     (w_pop),
        .o_cmd     (o_cmd)
    );

`ifndef SYNTHESIS
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(w_push && w_q_full && !w_pop))
        else $error("command queue overflow");

    a_pop_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_pop |-> w_q_valid)
        else $error("pop from empty command queue");

    a_present_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd.valid && o_cmd.op == atcr_pkg::OP_PRESENT) |-> o_cmd.last)
        else $error("present frame not marked last");

    a_geom_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_pop |=> (w_geom.cols >= atcr_pkg::MIN_COLUMNS && w_geom.cols <= MaxCols
                   && w_geom.rows >= atcr_pkg::MIN_ROWS && w_geom.rows <= MaxRows))
        else $error("geometry outside clamp range");
`endif

endmodule

[sim/ansi_text_console_renderer_tb.sv]
// testbench for the ansi text console renderer: predicts draw commands per byte and checks them
module ansi_text_console_renderer_tb;

    typedef struct {
        logic [7:0] ch;
        logic       eob;
    } t_text_byte;

    typedef struct {
        atcr_pkg::t_op op;
        logic [7:0]    col;
        logic [7:0]    row;
        logic [7:0]    glyph;
        logic [4:0]    color;
        logic          last;
    } t_console_cmd;

    localparam int SCREEN_MAX_COLS   = 256;
    localparam int SCREEN_MAX_ROWS   = 256;
    localparam int MAX_CMDS_PER_BYTE = 24;
    localparam int WATCHDOG_LIMIT    = 5000;
    localparam int DRAIN_CYCLES      = 40;
    localparam int MAX_REPORTS       = 10;

    logic i_clk;
    logic i_rst_n;

    atcr_in_if  in_ch ();
    atcr_cfg_if cfg_ch ();
    atcr_out_if cmd_ch ();

    ansi_text_console_renderer dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_char  (in_ch),
        .i_cfg   (cfg_ch),
        .o_cmd   (cmd_ch)
    );

    // predicted console state
    logic [8:0] cols_reg;
    logic [8:0] rows_reg;
    logic [7:0] cur_col;
    logic [7:0] cur_row;
    logic [4:0] draw_fg;
    logic [4:0] pend_color;
    logic       esc_seen;
    logic       in_sgr;
    logic [9:0] sgr_value;
    logic [1:0] sgr_digits;

    t_console_cmd expected_cmds[$];
    t_console_cmd step_cmds[$];
    t_text_byte   pending_bytes[$];

    int errors;
    int queued_bytes;
    int idle_odds;
    bit quiet;
    bit byte_held;
    int in_gap;
    int out_stall;
    int idle_cycles;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic int screen_cols();
        int c;
        c = int'(cols_reg);
        if (c < int'(atcr_pkg::MIN_COLUMNS)) c = int'(atcr_pkg::MIN_COLUMNS);
        if (c > SCREEN_MAX_COLS) c = SCREEN_MAX_COLS;
        return c;
    endfunction

    function automatic int screen_rows();
        int r;
        r = int'(rows_reg);
        if (r < int'(atcr_pkg::MIN_ROWS)) r = int'(atcr_pkg::MIN_ROWS);
        if (r > SCREEN_MAX_ROWS) r = SCREEN_MAX_ROWS;
        return r;
    endfunction

    function automatic void reset_console();
        cols_reg   = atcr_pkg::RESET_COLUMNS;
        rows_reg   = atcr_pkg::RESET_ROWS;
        cur_col    = '0;
        cur_row    = '0;
        draw_fg    = atcr_pkg::COLOR_WHITE;
        pend_color = atcr_pkg::COLOR_WHITE;
        esc_seen   = 1'b0;
        in_sgr     = 1'b0;
        sgr_value  = '0;
        sgr_digits = '0;
    endfunction

    function automatic void push_cmd(atcr_pkg::t_op op, logic [7:0] col, logic [7:0] row,
                                     logic [7:0] glyph, logic [4:0] color);
        t_console_cmd c;
        if (step_cmds.size() >= MAX_CMDS_PER_BYTE) return;
        c.op    = op;
        c.col   = col;
        c.row   = row;
        c.glyph = glyph;
        c.color = color;
        c.last  = 1'b0;
        step_cmds.push_back(c);
    endfunction

    function automatic void line_break();
        push_cmd(atcr_pkg::OP_CLEAR, cur_col, cur_row, 8'd0, 5'd0);
        cur_col = '0;
        // a cursor left below a shrunken screen stays put and scrolls
        if (int'(cur_row) + 1 < screen_rows())
            cur_row = cur_row + 8'd1;
        else
            push_cmd(atcr_pkg::OP_SCROLL, 8'd0, 8'd0, 8'd0, 5'd0);
    endfunction

    function automatic void wrap_check();
        if (int'(cur_col) + 1 >= screen_cols()) line_break();
    endfunction

    function automatic void plain_glyph(logic [7:0] ch);
        push_cmd(atcr_pkg::OP_DRAW, cur_col, cur_row, ch, draw_fg);
        cur_col = cur_col + 8'd1;
    endfunction

    function automatic void draw_cursor();
        push_cmd(atcr_pkg::OP_DRAW, cur_col, cur_row, atcr_pkg::CH_UNDERSCORE, draw_fg);
    endfunction

    function automatic void typeset(logic [7:0] ch);
        wrap_check();
        if (ch == atcr_pkg::CH_LF) begin
            line_break();
        end else if (ch == atcr_pkg::CH_CR) begin
            cur_col = '0;
        end else if (ch == atcr_pkg::CH_BS) begin
            push_cmd(atcr_pkg::OP_DRAW, cur_col, cur_row, atcr_pkg::CH_SPACE, draw_fg);
            if (cur_col != 8'd0) cur_col = cur_col - 8'd1;
        end else if (ch == atcr_pkg::CH_TAB) begin
            // each space of a tab wraps and draws its own cursor
            for (int i = 0; i <= int'(atcr_pkg::TAB_LAST); i++) begin
                wrap_check();
                plain_glyph(atcr_pkg::CH_SPACE);
                draw_cursor();
            end
        end else begin
            plain_glyph(ch);
        end
        draw_cursor();
    endfunction

    function automatic void apply_sgr_code(logic [9:0] code);
        if (code == 10'd0)
            pend_color = atcr_pkg::COLOR_WHITE;
        else if (code >= atcr_pkg::SGR_FG_LO && code <= atcr_pkg::SGR_FG_HI)
            pend_color = 5'(code - atcr_pkg::SGR_FG_LO);
        else if (code >= atcr_pkg::SGR_FG_BR_LO && code <= atcr_pkg::SGR_FG_BR_HI)
            pend_color = 5'(code - atcr_pkg::SGR_FG_BR_LO) + atcr_pkg::BRIGHT_OFFSET;
        else if (code >= atcr_pkg::SGR_BG_LO && code <= atcr_pkg::SGR_BG_HI)
            pend_color = 5'(code - atcr_pkg::SGR_BG_LO);
        else if (code >= atcr_pkg::SGR_BG_BR_LO && code <= atcr_pkg::SGR_BG_BR_HI)
            pend_color = 5'(code - atcr_pkg::SGR_BG_BR_LO) + atcr_pkg::BRIGHT_OFFSET;
    endfunction

    function automatic void console_step(logic [7:0] ch, logic eob);
        step_cmds.delete();
        if (ch == atcr_pkg::CH_ESC) begin
            esc_seen = 1'b1;
        end else if (ch == atcr_pkg::CH_LBRACKET && esc_seen) begin
            in_sgr     = 1'b1;
            sgr_digits = '0;
            sgr_value  = '0;
        end else if (in_sgr && ch >= atcr_pkg::CH_ZERO && ch <= atcr_pkg::CH_NINE) begin
            if (sgr_digits < atcr_pkg::MAX_DIGITS) begin
                sgr_value  = 10'(sgr_value * 10 + int'(ch - atcr_pkg::CH_ZERO));
                sgr_digits = sgr_digits + 2'd1;
            end
        end else if (in_sgr && (ch == atcr_pkg::CH_SEMI || ch == atcr_pkg::CH_M)) begin
            apply_sgr_code(sgr_value);
            sgr_value  = '0;
            sgr_digits = '0;
            if (ch == atcr_pkg::CH_M) begin
                draw_fg  = pend_color;
                esc_seen = 1'b0;
                in_sgr   = 1'b0;
            end
        end else begin
            typeset(ch);
        end
        if (eob) begin
            push_cmd(atcr_pkg::OP_PRESENT, 8'd0, 8'd0, 8'd0, 5'd0);
            esc_seen   = 1'b0;
            in_sgr     = 1'b0;
            sgr_value  = '0;
            sgr_digits = '0;
            pend_color = draw_fg;
        end
        if (step_cmds.size() > 0) step_cmds[step_cmds.size() - 1].last = 1'b1;
        foreach (step_cmds[i]) expected_cmds.push_back(step_cmds[i]);
    endfunction

    function automatic void check_cmd();
        t_console_cmd want;
        if (expected_cmds.size() == 0) begin
            errors++;
            if (errors <= MAX_REPORTS)
                $display("unexpected command: op=%0d col=%0d row=%0d glyph=%0d color=%0d last=%0d",
                         cmd_ch.op, cmd_ch.cell_col, cmd_ch.cell_row, cmd_ch.glyph,
                         cmd_ch.color_index, cmd_ch.last);
            return;
        end
        want = expected_cmds.pop_front();
        if (cmd_ch.op !== want.op || cmd_ch.cell_col !== want.col ||
            cmd_ch.cell_row !== want.row || cmd_ch.glyph !== want.glyph ||
            cmd_ch.color_index !== want.color || cmd_ch.last !== want.last) begin
            errors++;
            if (errors <= MAX_REPORTS) begin
                $display("command mismatch: expected op=%0d col=%0d row=%0d glyph=%0d color=%0d last=%0d",
                         want.op, want.col, want.row, want.glyph, want.color, want.last);
                $display("                  got      op=%0d col=%0d row=%0d glyph=%0d color=%0d last=%0d",
                         cmd_ch.op, cmd_ch.cell_col, cmd_ch.cell_row, cmd_ch.glyph,
                         cmd_ch.color_index, cmd_ch.last);
            end
        end
    endfunction

    // byte driver
    always @(posedge i_clk) begin : byte_driver
        t_text_byte nxt;
        if (!i_rst_n) begin
            in_ch.valid         <= 1'b0;
            in_ch.char_code     <= 8'd0;
            in_ch.end_of_buffer <= 1'b0;
            in_gap              <= 0;
        end else begin
            if (in_ch.valid && in_ch.ready) begin
                console_step(in_ch.char_code, in_ch.end_of_buffer);
                byte_held = 1'b0;
            end
            if (!in_ch.valid || in_ch.ready) begin
                if (in_gap > 0) begin
                    in_gap      <= in_gap - 1;
                    in_ch.valid <= 1'b0;
                end else if (pending_bytes.size() == 0) begin
                    in_ch.valid <= 1'b0;
                end else if (!quiet && idle_odds >= 2 &&
                             $urandom_range(idle_odds - 1, 0) == 0) begin
                    in_gap      <= $urandom_range(18, 0);
                    in_ch.valid <= 1'b0;
                end else begin
                    nxt = pending_bytes.pop_front();
                    byte_held = 1'b1;
                    in_ch.valid         <= 1'b1;
                    in_ch.char_code     <= nxt.ch;
                    in_ch.end_of_buffer <= nxt.eob;
                end
            end
        end
    end

    // command monitor
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            cmd_ch.ready <= 1'b0;
            out_stall    <= 0;
        end else begin
            if (cmd_ch.valid && cmd_ch.ready) check_cmd();
            if (out_stall > 0) begin
                out_stall    <= out_stall - 1;
                cmd_ch.ready <= 1'b0;
            end else if (!quiet && idle_odds >= 2 &&
                         $urandom_range(idle_odds - 1, 0) == 0) begin
                out_stall    <= $urandom_range(18, 0);
                cmd_ch.ready <= 1'b0;
            end else begin
                cmd_ch.ready <= 1'b1;
            end
        end
    end

    // watchdog on cycles without any transfer
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            idle_cycles <= 0;
        end else if ((in_ch.valid && in_ch.ready) || (cmd_ch.valid && cmd_ch.ready) ||
                     (cfg_ch.valid && cfg_ch.ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("ansi_text_console_renderer_tb: done, errors");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    function automatic void add_byte(logic [7:0] ch, logic eob);
        t_text_byte b;
        b.ch  = ch;
        b.eob = eob;
        pending_bytes.push_back(b);
        queued_bytes++;
    endfunction

    function automatic void add_text(string s);
        for (int i = 0; i < s.len(); i++) add_byte(s[i], 1'b0);
    endfunction

    function automatic void add_csi(string body);
        add_byte(atcr_pkg::CH_ESC, 1'b0);
        add_byte(atcr_pkg::CH_LBRACKET, 1'b0);
        add_text(body);
    endfunction

    function automatic string sgr_code_text();
        case ($urandom_range(5, 0))
            0: return $sformatf("%0d", int'(atcr_pkg::SGR_FG_LO) + $urandom_range(7, 0));
            1: return $sformatf("%0d", int'(atcr_pkg::SGR_BG_LO) + $urandom_range(7, 0));
            2: return $sformatf("%0d", int'(atcr_pkg::SGR_FG_BR_LO) + $urandom_range(7, 0));
            3: return $sformatf("%0d", int'(atcr_pkg::SGR_BG_BR_LO) + $urandom_range(7, 0));
            4: begin
                if ($urandom_range(2, 0) == 0) return "";
                return $sformatf("%0d", $urandom_range(999, 0));
            end
            default: return $sformatf("%0d", $urandom_range(9999, 1000));
        endcase
    endfunction

    function automatic void add_token();
        int    pick;
        int    k;
        string body;
        pick = $urandom_range(99, 0);
        if (pick < 35) begin
            add_byte(8'($urandom_range(255, 0)), 1'b0);
        end else if (pick < 50) begin
            case ($urandom_range(3, 0))
                0: add_byte(atcr_pkg::CH_LF, 1'b0);
                1: add_byte(atcr_pkg::CH_CR, 1'b0);
                2: add_byte(atcr_pkg::CH_BS, 1'b0);
                default: add_byte(atcr_pkg::CH_TAB, 1'b0);
            endcase
        end else if (pick < 75) begin
            k = $urandom_range(3, 1);
            body = "";
            for (int i = 0; i < k; i++) begin
                body = {body, sgr_code_text()};
                if (i == k - 1)
                    body = {body, "m"};
                else
                    body = {body, ";"};
            end
            add_csi(body);
        end else if (pick < 85) begin
            // broken sequences: lone escape, no closing m, stray separators
            case ($urandom_range(2, 0))
                0: begin
                    add_byte(atcr_pkg::CH_ESC, 1'b0);
                    add_byte(8'($urandom_range(255, 0)), 1'b0);
                end
                1: add_csi({sgr_code_text(), ";"});
                default: add_text(";m7");
            endcase
        end else begin
            add_byte(8'($urandom_range(255, 0)), 1'b1);
        end
    endfunction

    function automatic void add_random(int n);
        int target;
        target = queued_bytes + n;
        while (queued_bytes < target) add_token();
    endfunction

    task automatic settle();
        while (pending_bytes.size() != 0 || byte_held || expected_cmds.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic idx, input logic [8:0] val);
        @(posedge i_clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= val;
        do @(posedge i_clk); while (!cfg_ch.ready);
        cfg_ch.valid <= 1'b0;
        if (idx == atcr_pkg::REG_TEXT_COLUMNS)
            cols_reg = val;
        else
            rows_reg = val;
    endtask

    initial begin
        i_rst_n             = 1'b0;
        cfg_ch.valid        = 1'b0;
        cfg_ch.index        = atcr_pkg::REG_TEXT_COLUMNS;
        cfg_ch.data         = 9'd0;
        errors       = 0;
        queued_bytes = 0;
        idle_odds    = 6;
        quiet        = 1'b0;
        byte_held    = 1'b0;
        reset_console();
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: field extremes, controls, colour sequences and their corner cases
        add_text("A");
        add_byte(8'h00, 1'b0);
        add_byte(8'hFF, 1'b0);
        add_byte(atcr_pkg::CH_BS, 1'b0);
        add_byte(atcr_pkg::CH_CR, 1'b0);
        add_byte(atcr_pkg::CH_BS, 1'b0);
        add_byte(atcr_pkg::CH_TAB, 1'b0);
        add_byte(atcr_pkg::CH_LF, 1'b0);
        add_csi("5555;m");
        add_csi("31m");
        add_text("x");
        add_byte(atcr_pkg::CH_ESC, 1'b0);
        add_text("q");
        add_csi("42");
        add_byte(atcr_pkg::CH_SEMI, 1'b1);
        add_byte(8'h7A, 1'b1);
        settle();

        idle_odds = 4;
        add_random(30);
        settle();

        // narrowest screen: wraps and scrolls on nearly every byte
        write_reg(atcr_pkg::REG_TEXT_COLUMNS, 9'd2);
        write_reg(atcr_pkg::REG_TEXT_ROWS, 9'd1);
        idle_odds = 3;
        add_random(25);
        settle();

        // out-of-range low values clamp to the minimum
        write_reg(atcr_pkg::REG_TEXT_COLUMNS, 9'd0);
        write_reg(atcr_pkg::REG_TEXT_ROWS, 9'd0);
        idle_odds = 0;
        add_random(20);
        settle();

        // out-of-range high values clamp to the maximum
        write_reg(atcr_pkg::REG_TEXT_COLUMNS, 9'd511);
        write_reg(atcr_pkg::REG_TEXT_ROWS, 9'd511);
        idle_odds = 8;
        repeat (20) add_byte(atcr_pkg::CH_LF, 1'b0);
        add_random(20);
        settle();

        // shrink the screen under the cursor
        write_reg(atcr_pkg::REG_TEXT_COLUMNS, 9'($urandom_range(40, 2)));
        write_reg(atcr_pkg::REG_TEXT_ROWS, 9'd3);
        idle_odds = 5;
        add_byte(atcr_pkg::CH_LF, 1'b0);
        add_text("a");
        add_byte(atcr_pkg::CH_LF, 1'b0);
        add_random(30);
        settle();

        write_reg(atcr_pkg::REG_TEXT_COLUMNS, 9'd256);
        write_reg(atcr_pkg::REG_TEXT_ROWS, 9'($urandom_range(8, 1)));
        idle_odds = 6;
        add_random(20);
        settle();

        quiet = 1'b1;
        add_random(30);
        settle();

        if (errors == 0 && expected_cmds.size() == 0)
            $display("ansi_text_console_renderer_tb: done, clean");
        else
            $display("ansi_text_console_renderer_tb: done, errors");
        $finish;
    end

endmodule
